// ===== rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: action codes and the queue word type.
// No dependencies.
`default_nettype none
package cau_pkg;
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_MAG = 3'd4;
	localparam logic [2:0] ACT_CONJ = 3'd5;
	localparam logic [2:0] ACT_NEG = 3'd6;
	localparam logic [2:0] ACT_EQ = 3'd7;

	// One classified word as it travels from the front to the back.
	typedef struct packed {
		logic [2:0] action;
		logic [31:0] a_re;
		logic [31:0] a_im;
		logic [31:0] b_re;
		logic [31:0] b_im;
	} cau_word_t;
endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
// Front end: accepts input words and places them in a two-entry queue.
// Depends on cau_pkg.
`default_nettype none
module cau_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cau_pkg::cau_word_t in_word,
	output logic q_valid,
	input wire logic q_ready,
	output cau_pkg::cau_word_t q_word
);
	cau_pkg::cau_word_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_word = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cau_back.sv =====
// Back end: simple actions at once, mul from products, div/mag on an iterative unit.
// Depends on cau_pkg.
`default_nettype none
module cau_back #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire cau_pkg::cau_word_t q_word,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic is_equal,
	output logic div_by_zero,
	output logic saturated
);
	localparam int W = WORD_BITS;
	localparam int PW = 2 * W + 2;          // products and sums
	localparam int NW = PW + FRAC_BITS;     // shifted numerators
	localparam int CW = $clog2(NW + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PROD = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;

	logic [1:0] st_q;
	logic [2:0] act_q;
	logic signed [W-1:0] ar, ai, br, bi;
	logic signed [W-1:0] ar_q, ai_q, br_q, bi_q;
	logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
	logic [NW-1:0] nr_q, ni_q, rr_q, ri_q, qr_q, qi_q, den_q;
	logic nr_neg_q, ni_neg_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] sq_n_q, sq_r_q, sq_b_q;
	logic o_valid_q;
	logic signed [PW-1:0] fast_re, fast_im;
	logic signed [NW:0] fin_re, fin_im;
	logic accept, out_free;

	assign ar = W'(q_word.a_re);
	assign ai = W'(q_word.a_im);
	assign br = W'(q_word.b_re);
	assign bi = W'(q_word.b_im);
	assign out_free = !o_valid_q || out_ready;
	assign q_ready = (st_q == ST_IDLE) && out_free;
	assign accept = q_valid && q_ready;
	assign out_valid = o_valid_q;

	function automatic logic [31:0] sat_word(input logic signed [NW:0] v, output logic s);
		logic signed [NW:0] mx, mn;
		logic signed [W-1:0] r;
		begin
			mx = (NW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
			mn = -mx - (NW+1)'(1);
			s = 1'b0;
			if (v > mx) begin r = mx[W-1:0]; s = 1'b1; end
			else if (v < mn) begin r = mn[W-1:0]; s = 1'b1; end
			else r = v[W-1:0];
			sat_word = 32'($unsigned(r));
		end
	endfunction

	always_comb begin
		fast_re = '0;
		fast_im = '0;
		case (q_word.action)
			cau_pkg::ACT_ADD: begin
				fast_re = PW'(ar) + PW'(br);
				fast_im = PW'(ai) + PW'(bi);
			end
			cau_pkg::ACT_SUB: begin
				fast_re = PW'(ar) - PW'(br);
				fast_im = PW'(ai) - PW'(bi);
			end
			cau_pkg::ACT_CONJ: begin
				fast_re = PW'(ar);
				fast_im = -PW'(ai);
			end
			cau_pkg::ACT_NEG: begin
				fast_re = -PW'(ar);
				fast_im = -PW'(ai);
			end
			default: begin
				fast_re = '0;
				fast_im = '0;
			end
		endcase
	end

	// Floor results of the finished iterative work.
	always_comb begin
		fin_re = '0;
		fin_im = '0;
		case (act_q)
			cau_pkg::ACT_MUL: begin
				fin_re = (NW+1)'(p0_q >>> FRAC_BITS);
				fin_im = (NW+1)'(p1_q >>> FRAC_BITS);
			end
			cau_pkg::ACT_DIV: begin
				fin_re = nr_neg_q ? -$signed({1'b0, qr_q}) - (NW+1)'(rr_q != '0)
					: $signed({1'b0, qr_q});
				fin_im = ni_neg_q ? -$signed({1'b0, qi_q}) - (NW+1)'(ri_q != '0)
					: $signed({1'b0, qi_q});
			end
			default: begin
				fin_re = $signed({{(NW+1-PW){1'b0}}, sq_r_q});
				fin_im = '0;
			end
		endcase
	end

	logic [NW-1:0] tr, ti, sr, si;
	logic [PW-1:0] sq_t;
	always_comb begin
		tr = {rr_q[NW-2:0], nr_q[NW-1]};
		ti = {ri_q[NW-2:0], ni_q[NW-1]};
		sr = tr - den_q;
		si = ti - den_q;
		sq_t = sq_r_q + sq_b_q;
	end

	always_ff @(posedge clk) begin
		logic s0, s1;
		logic signed [PW-1:0] d, nrv, niv;
		if (accept) begin
			act_q <= q_word.action;
			ar_q <= ar; ai_q <= ai; br_q <= br; bi_q <= bi;
		end
		case (st_q)
			ST_PROD: begin
				// products registered in the previous cycle, now combine
				d = p0_q + p1_q;
				if (act_q == cau_pkg::ACT_MUL) begin
					p0_q <= p0_q - p1_q;
					p1_q <= p2_q + p3_q;
				end else if (act_q == cau_pkg::ACT_DIV) begin
					nrv = p0_q + p1_q;
					niv = p3_q - p2_q;
					den_q <= NW'(PW'(br_q * br_q) + PW'(bi_q * bi_q));
					nr_neg_q <= nrv < 0;
					ni_neg_q <= niv < 0;
					nr_q <= NW'(nrv < 0 ? -nrv : nrv) << FRAC_BITS;
					ni_q <= NW'(niv < 0 ? -niv : niv) << FRAC_BITS;
					rr_q <= '0; ri_q <= '0; qr_q <= '0; qi_q <= '0;
					cnt_q <= CW'(NW);
				end else begin
					sq_n_q <= $unsigned(d);
					sq_r_q <= '0;
					sq_b_q <= PW'(1) << (2 * W - 2);
					cnt_q <= CW'(W);
				end
			end
			ST_ITER: begin
				if (act_q == cau_pkg::ACT_DIV) begin
					nr_q <= nr_q << 1;
					ni_q <= ni_q << 1;
					rr_q <= (tr >= den_q) ? sr : tr;
					ri_q <= (ti >= den_q) ? si : ti;
					qr_q <= {qr_q[NW-2:0], tr >= den_q};
					qi_q <= {qi_q[NW-2:0], ti >= den_q};
				end else begin
					if (sq_n_q >= sq_t) begin
						sq_n_q <= sq_n_q - sq_t;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
				end
				cnt_q <= cnt_q - CW'(1);
			end
			default: begin
				if (accept) begin
					if (q_word.action == cau_pkg::ACT_MUL) begin
						p0_q <= PW'(ar * br); p1_q <= PW'(ai * bi);
						p2_q <= PW'(ar * bi); p3_q <= PW'(ai * br);
					end else if (q_word.action == cau_pkg::ACT_DIV) begin
						p0_q <= PW'(ar * br); p1_q <= PW'(ai * bi);
						p2_q <= PW'(ar * bi); p3_q <= PW'(ai * br);
					end else begin
						p0_q <= PW'(ar * ar); p1_q <= PW'(ai * ai);
					end
				end
			end
		endcase
		if (accept && !(q_word.action == cau_pkg::ACT_MUL || q_word.action == cau_pkg::ACT_DIV
			|| q_word.action == cau_pkg::ACT_MAG)) begin
			res_re <= sat_word((NW+1)'(fast_re), s0);
			res_im <= sat_word((NW+1)'(fast_im), s1);
			saturated <= s0 | s1;
			is_equal <= (q_word.action == cau_pkg::ACT_EQ) && (ar == br) && (ai == bi);
			div_by_zero <= 1'b0;
		end else if (accept && q_word.action == cau_pkg::ACT_DIV && br == '0 && bi == '0) begin
			res_re <= '0; res_im <= '0; saturated <= 1'b0;
			is_equal <= 1'b0; div_by_zero <= 1'b1;
		end else if ((st_q == ST_ITER && cnt_q == '0) ||
			(st_q == ST_PROD && act_q == cau_pkg::ACT_MUL)) begin
			if (st_q == ST_PROD) begin
				res_re <= sat_word((NW+1)'((p0_q - p1_q) >>> FRAC_BITS), s0);
				res_im <= sat_word((NW+1)'((p2_q + p3_q) >>> FRAC_BITS), s1);
			end else begin
				res_re <= sat_word(fin_re, s0);
				res_im <= sat_word(fin_im, s1);
			end
			saturated <= s0 | s1;
			is_equal <= 1'b0; div_by_zero <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			o_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_PROD: begin
					if (act_q == cau_pkg::ACT_MUL) begin
						st_q <= ST_IDLE;
						o_valid_q <= 1'b1;
					end else st_q <= ST_ITER;
				end
				ST_ITER: begin
					if (cnt_q == '0) begin
						st_q <= ST_IDLE;
						o_valid_q <= 1'b1;
					end
				end
				default: begin
					if (out_ready) o_valid_q <= 1'b0;
					if (accept) begin
						if ((q_word.action == cau_pkg::ACT_MUL) || (q_word.action ==
							cau_pkg::ACT_MAG) || (q_word.action == cau_pkg::ACT_DIV &&
							!(br == '0 && bi == '0)))
							st_q <= ST_PROD;
						else o_valid_q <= 1'b1;
					end
				end
			endcase
		end
	end
	logic unused;
	assign unused = ^{ar_q, ai_q};
endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front queue and execution back end.
// Depends on cau_pkg, cau_front and cau_back.
`default_nettype none
// Channel | Direction | Handshake              | Payload
// s_axis  | in        | s_axis_tvalid/tready   | tuser action, tdata a_re,a_im,b_re,b_im
// m_axis  | out       | m_axis_tvalid/tready   | tdata res_re,res_im,is_equal,div_by_zero,
//         |           |                        | saturated
// Add, subtract, conjugate, negate, equality and division by zero are finished on
// acceptance and follow back to back. A multiply occupies the back end through the
// product state; a divide and a magnitude go on through the iteration state, the
// one-bit-a-step restoring divider and square-root loop. The back end takes a new
// word only when its output register is empty or being read. The two-word queue
// keeps the input side open while the back end works. Reset empties the queue
// and the output register.
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
	input wire logic [2:0] s_axis_tuser,    // action
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [71:0] m_axis_tdata        // res_re, res_im, is_equal, div_by_zero,
	                                        // saturated, zero fill
);
	cau_pkg::cau_word_t in_word, q_word;
	logic q_valid, q_ready;
	logic [31:0] re, im;
	logic eq, dz, sat;

	assign in_word.action = s_axis_tuser;
	assign in_word.a_re = s_axis_tdata[31:0];
	assign in_word.a_im = s_axis_tdata[63:32];
	assign in_word.b_re = s_axis_tdata[95:64];
	assign in_word.b_im = s_axis_tdata[127:96];

	cau_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_word(in_word), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
	);

	cau_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res_re(re), .res_im(im),
		.is_equal(eq), .div_by_zero(dz), .saturated(sat)
	);

	assign m_axis_tdata = {5'd0, sat, dz, eq, im, re};
endmodule
`default_nettype wire
